// ----- rtl/gfpd_pkg.sv -----
// Shared types, constants and field arithmetic for the GF polynomial divider.
`default_nettype none
package gfpd_pkg;

    localparam int SYM_W      = 8;
    localparam int MAX_DEG    = 16;
    localparam int IDX_W      = (MAX_DEG > 1) ? $clog2(MAX_DEG) : 1;
    localparam int DEG_W      = 5;
    localparam int FIELD_W    = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_PITCH = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_INV   = 3'd4;

    typedef logic [SYM_W-1:0] t_sym;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic step;
        logic fb;
    } t_cell_ctl;

    typedef struct packed {
        logic               last;
        logic               kind;
        logic [FIELD_W-1:0] symbol;
    } t_res;

    // product modulo x^SYM_W + poly
    function automatic t_sym gf_mul(t_sym a, t_sym b, t_sym poly);
        t_sym r;
        r = '0;
        for (int i = SYM_W - 1; i >= 0; i--) begin
            r = {r[SYM_W-2:0], 1'b0} ^ (r[SYM_W-1] ? poly : t_sym'(0));
            if (b[i]) begin
                r = r ^ a;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/gf_polynomial_divider.sv -----
// Top level: streaming divider of polynomials over GF(2^8) by a configured divisor.
//
// Dividend coefficients enter on s_axis highest degree first, coefficient in
// tdata, tlast on the constant term. Results leave on m_axis: symbol in tdata,
// tuser 0 for a quotient and 1 for a remainder coefficient, tlast on the last
// result an input beat causes.
// Each beat updates a chain of 16 remainder cells at once and queues its
// quotient coefficient, which the output queue registers before m_axis shows
// it. After a final beat the chain shifts its top cell out d times (d =
// divisor degree, clamped to 1..16), which also clears the cells in use; no
// input is taken meanwhile.
// Configuration goes through i_cfg_we/i_cfg_index/i_cfg_data while idle; the
// cells pre-scale the divisor by the lead inverse, so input is held off in
// the cycle after each write.
// Synchronous reset clears the cells and the queue, loads default settings and
// holds input off in the first cycle after reset.
// A two-beat output queue decouples the sides: input and draining continue
// while one result waits; the queue stops them only when it is full.
`default_nettype none
module gf_polynomial_divider (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gfpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gfpd_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,  // [7:0] coefficient
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [7:0]                           m_axis_tdata,  // [7:0] symbol
    output logic                                 m_axis_tuser,  // [0] kind
    output logic                                 m_axis_tlast
);

    localparam int SYM_W   = gfpd_pkg::SYM_W;
    localparam int MAX_DEG = gfpd_pkg::MAX_DEG;
    localparam int IDX_W   = gfpd_pkg::IDX_W;
    localparam int DEG_W   = gfpd_pkg::DEG_W;
    localparam int CFG_W   = gfpd_pkg::CFG_W;
    localparam int PITCH   = gfpd_pkg::COEF_PITCH;

    logic [gfpd_pkg::FIELD_W-1:0] r_poly;
    logic [DEG_W-1:0]             r_deg;
    logic [CFG_W-1:0]             r_low;
    logic [CFG_W-1:0]             r_high;
    logic [gfpd_pkg::FIELD_W-1:0] r_linv;
    logic                         r_busy;

    gfpd_pkg::t_state    r_state;
    gfpd_pkg::t_state    n_state;
    logic [DEG_W-1:0]    r_cnt;
    logic [DEG_W-1:0]    n_cnt;

    logic [DEG_W-1:0]    w_deff;
    logic [IDX_W-1:0]    w_didx;
    logic [2*CFG_W-1:0]  w_coef_all;
    gfpd_pkg::t_sym      w_sym [MAX_DEG];
    logic [MAX_DEG-1:0]  w_active;
    gfpd_pkg::t_sym      w_top;
    gfpd_pkg::t_sym      w_q;
    gfpd_pkg::t_sym      w_poly;
    gfpd_pkg::t_sym      w_linv;
    gfpd_pkg::t_sym      w_cin;
    gfpd_pkg::t_cell_ctl w_ctl;
    logic                w_space;
    logic                w_accept;
    logic                w_drain;
    logic                w_push;
    gfpd_pkg::t_res      w_res;
    gfpd_pkg::t_res      w_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= 8'd29;
            r_deg  <= 5'd1;
            r_low  <= '0;
            r_high <= '0;
            r_linv <= 8'd1;
            r_busy <= 1'b1;
        end else begin
            r_busy <= i_cfg_we;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    gfpd_pkg::CFG_FIELD_POLY: r_poly <= i_cfg_data[gfpd_pkg::FIELD_W-1:0];
                    gfpd_pkg::CFG_DEGREE:     r_deg  <= i_cfg_data[DEG_W-1:0];
                    gfpd_pkg::CFG_COEF_LOW:   r_low  <= i_cfg_data;
                    gfpd_pkg::CFG_COEF_HIGH:  r_high <= i_cfg_data;
                    gfpd_pkg::CFG_LEAD_INV:   r_linv <= i_cfg_data[gfpd_pkg::FIELD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // degree clamped to 1..MAX_DEG
    always_comb begin
        w_deff = r_deg;
        if (r_deg == '0) begin
            w_deff = DEG_W'(1);
        end else if (r_deg > DEG_W'(MAX_DEG)) begin
            w_deff = DEG_W'(MAX_DEG);
        end
    end

    assign w_didx     = IDX_W'(w_deff - DEG_W'(1));
    assign w_coef_all = {r_high, r_low};
    assign w_poly     = r_poly[SYM_W-1:0];
    assign w_linv     = r_linv[SYM_W-1:0];
    assign w_top      = w_sym[w_didx];
    assign w_q        = gfpd_pkg::gf_mul(w_top, w_linv, w_poly);
    assign w_cin      = w_ctl.fb ? s_axis_tdata[SYM_W-1:0] : gfpd_pkg::t_sym'(0);

    for (genvar g = 0; g < MAX_DEG; g++) begin : g_cell
        gfpd_pkg::t_sym w_prev;

        assign w_active[g] = (DEG_W'(g) < w_deff);

        if (g == 0) begin : g_first
            assign w_prev = w_cin;
        end else begin : g_rest
            assign w_prev = w_sym[g-1];
        end

        gfpd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_active   (w_active[g]),
            .i_prev     (w_prev),
            .i_top      (w_top),
            .i_coef_raw (w_coef_all[PITCH*g +: SYM_W]),
            .i_lead_inv (w_linv),
            .i_poly     (w_poly),
            .o_sym      (w_sym[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            gfpd_pkg::ST_RUN: begin
                if (w_accept && s_axis_tlast) begin
                    n_state = gfpd_pkg::ST_DRAIN;
                    n_cnt   = w_deff;
                end
            end
            gfpd_pkg::ST_DRAIN: begin
                if (w_drain) begin
                    n_cnt = r_cnt - DEG_W'(1);
                    if (r_cnt == DEG_W'(1)) begin
                        n_state = gfpd_pkg::ST_RUN;
                    end
                end
            end
            default: n_state = gfpd_pkg::ST_RUN;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        w_drain       = 1'b0;
        case (r_state)
            gfpd_pkg::ST_RUN:   s_axis_tready = !r_busy && w_space;
            gfpd_pkg::ST_DRAIN: w_drain       = w_space;
            default: ;
        endcase
        w_accept   = s_axis_tvalid && s_axis_tready;
        w_push     = w_accept || w_drain;
        w_ctl.step = w_push;
        w_ctl.fb   = w_accept;
        if (w_drain) begin
            w_res.symbol = gfpd_pkg::FIELD_W'(w_top);
            w_res.kind   = 1'b1;
            w_res.last   = (r_cnt == DEG_W'(1));
        end else begin
            w_res.symbol = gfpd_pkg::FIELD_W'(w_q);
            w_res.kind   = 1'b0;
            w_res.last   = !s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gfpd_pkg::ST_RUN;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    gfpd_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_head),
        .o_space (w_space)
    );

    assign m_axis_tdata = w_head.symbol;
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> (r_state == gfpd_pkg::ST_DRAIN))
        else $error("final beat did not start remainder drain");

    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gfpd_pkg::ST_DRAIN) |-> (!s_axis_tready && r_cnt != '0))
        else $error("input taken or count empty during drain");

    a_cells_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_drain && r_cnt == DEG_W'(1)) |=> (w_sym[0] == '0))
        else $error("remainder cells not cleared after drain");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_space)
        else $error("result pushed into full queue");

endmodule
`default_nettype wire

// ----- rtl/gfpd_cell.sv -----
// One remainder cell: holds a symbol and its pre-scaled divisor coefficient.
`default_nettype none
module gfpd_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire gfpd_pkg::t_cell_ctl i_ctl,
    input  wire logic                i_active,
    input  wire gfpd_pkg::t_sym      i_prev,
    input  wire gfpd_pkg::t_sym      i_top,
    input  wire gfpd_pkg::t_sym      i_coef_raw,
    input  wire gfpd_pkg::t_sym      i_lead_inv,
    input  wire gfpd_pkg::t_sym      i_poly,
    output gfpd_pkg::t_sym           o_sym
);

    gfpd_pkg::t_sym r_sym;
    gfpd_pkg::t_sym n_sym;
    gfpd_pkg::t_sym r_coef;
    gfpd_pkg::t_sym n_coef;
    gfpd_pkg::t_sym w_prod;

    // coefficient times lead inverse, so one multiply per step
    assign n_coef = gfpd_pkg::gf_mul(i_coef_raw, i_lead_inv, i_poly);
    assign w_prod = gfpd_pkg::gf_mul(i_top, r_coef, i_poly);

    always_comb begin
        n_sym = r_sym;
        if (i_ctl.step && i_active) begin
            n_sym = i_prev ^ (i_ctl.fb ? w_prod : gfpd_pkg::t_sym'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= '0;
        end else begin
            r_sym <= n_sym;
        end
    end

    assign o_sym = r_sym;

endmodule
`default_nettype wire

// ----- rtl/gfpd_out_fifo.sv -----
// Two-entry result queue between the cell chain and the output stream.
`default_nettype none
module gfpd_out_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gfpd_pkg::t_res i_data,
    input  wire logic           i_ready,
    output logic                o_valid,
    output gfpd_pkg::t_res      o_data,
    output logic                o_space
);

    gfpd_pkg::t_res r_mem [2];
    logic           r_rd;
    logic           r_wr;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign o_data  = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire
